>>> design/lwq_pkg.sv
// ----------------------------------------------------------------------------
// lwq_pkg
// Shared constants, codes and types of the linked wait queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lwq_pkg;

    // Identifier space and link table
    localparam int ID_COUNT    = 64;
    localparam int ID_W        = 6;
    localparam int TABLE_DEPTH = 1 << ID_W;
    localparam int CNT_W       = (ID_COUNT > 2) ? $clog2(ID_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ID_COUNT - 2);

    // Stream widths
    localparam int DATA_W = 8;
    localparam int USER_W = 2;

    // Request modes
    localparam logic [1:0] MODE_WAIT   = 2'd0;
    localparam logic [1:0] MODE_SIGNAL = 2'd1;
    localparam logic [1:0] MODE_BCAST  = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    // Result status
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

endpackage

`default_nettype wire

>>> design/lwq_ram.sv
// ----------------------------------------------------------------------------
// lwq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/linked_wait_queue_top.sv
// ----------------------------------------------------------------------------
// linked_wait_queue_top
// FIFO wait queue of thread identifiers kept as a linked list in a
// next-pointer RAM; wait appends, signal pops the head, broadcast pops all.
// ----------------------------------------------------------------------------
// Flow: an accepted item moves to the execute state, which writes its result
//   into the output register once that register is free.
// Input: no new item is taken until the current one has written its last
//   result; a broadcast passes a read state to fetch each next link from RAM.
// Reset: synchronous, active low; per-entry valid bits clear the link table
//   at once (no clearing pass), the queue is empty right after reset.
`default_nettype none

module linked_wait_queue_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [lwq_pkg::DATA_W-1:0] i_s_axis_tdata,  // [5:0] thread_id
    input  wire logic [lwq_pkg::USER_W-1:0] i_s_axis_tuser,  // [1:0] mode
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic      [lwq_pkg::DATA_W-1:0] o_m_axis_tdata,  // [5:0] woken_id
    output logic      [lwq_pkg::USER_W-1:0] o_m_axis_tuser,  // [1:0] status
    output logic                            o_m_axis_tlast
);

    localparam int IW = lwq_pkg::ID_W;
    localparam int CW = lwq_pkg::CNT_W;

    lwq_pkg::t_state r_state, n_state;
    logic [1:0]    r_mode, n_mode;
    logic [IW-1:0] r_id, n_id;
    logic [IW-1:0] r_addr, n_addr;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [lwq_pkg::TABLE_DEPTH-1:0] r_valid;

    logic          r_out_valid, n_out_valid;
    logic [IW-1:0] r_out_id, n_out_id;
    logic [1:0]    r_out_st, n_out_st;
    logic          r_out_last, n_out_last;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] wr_data;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] ram_q;
    logic [IW-1:0] link;
    logic          out_free;
    logic          bad;
    logic          last_v;

    lwq_ram #(
        .WIDTH (IW),
        .DEPTH (lwq_pkg::TABLE_DEPTH)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    // Entries never written since reset read as an end-of-list link
    assign link     = r_valid[r_addr] ? ram_q : '0;
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_id        = r_id;
        n_addr      = r_addr;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_id    = r_out_id;
        n_out_st    = r_out_st;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        wr_addr     = r_addr;
        wr_data     = '0;
        rd_addr     = r_addr;
        o_s_axis_tready = 1'b0;
        bad         = 1'b0;
        last_v      = 1'b0;

        case (r_state)
            lwq_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                rd_addr = (i_s_axis_tuser == lwq_pkg::MODE_WAIT) ?
                          i_s_axis_tdata[IW-1:0] : r_head;
                if (i_s_axis_tvalid) begin
                    n_mode  = i_s_axis_tuser;
                    n_id    = i_s_axis_tdata[IW-1:0];
                    n_addr  = rd_addr;
                    n_count = '0;
                    // drop unused mode without a result
                    n_state = (i_s_axis_tuser == lwq_pkg::MODE_RSVD) ?
                              lwq_pkg::S_IDLE : lwq_pkg::S_EXEC;
                end
            end

            lwq_pkg::S_READ: begin
                n_state = lwq_pkg::S_EXEC;
            end

            lwq_pkg::S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = '0;
                    n_out_last  = 1'b1;
                    n_state     = lwq_pkg::S_IDLE;
                    case (r_mode)
                        lwq_pkg::MODE_WAIT: begin
                            bad = (r_id == '0) ||
                                  ({1'b0, r_id} >= (IW + 1)'(lwq_pkg::ID_COUNT)) ||
                                  (link != '0) || (r_id == r_tail);
                            if (bad) begin
                                n_out_st = lwq_pkg::ST_REJECT;
                            end else begin
                                n_out_st = lwq_pkg::ST_OK;
                                if (r_tail == '0) begin
                                    n_head = r_id;
                                end else begin
                                    wr_en   = 1'b1;
                                    wr_addr = r_tail;
                                    wr_data = r_id;
                                end
                                n_tail = r_id;
                            end
                        end
                        lwq_pkg::MODE_SIGNAL, lwq_pkg::MODE_BCAST: begin
                            if (r_head == '0) begin
                                n_out_st = lwq_pkg::ST_EMPTY;
                            end else begin
                                // pop head: unlink it and advance
                                n_out_id = r_head;
                                n_out_st = lwq_pkg::ST_OK;
                                n_head   = link;
                                if (link == '0) begin
                                    n_tail = '0;
                                end
                                wr_en   = 1'b1;
                                wr_addr = r_head;
                                wr_data = '0;
                                if (r_mode == lwq_pkg::MODE_BCAST) begin
                                    last_v     = (link == '0) || (r_count == lwq_pkg::CNT_LAST);
                                    n_out_last = last_v;
                                    if (!last_v) begin
                                        n_count = r_count + 1'b1;
                                        n_addr  = link;
                                        n_state = lwq_pkg::S_READ;
                                    end
                                end
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && !i_m_axis_tready;
                        end
                    endcase
                end
            end

            default: begin
                n_state = lwq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lwq_pkg::S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_id       <= n_id;
        r_addr     <= n_addr;
        r_out_id   <= n_out_id;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(lwq_pkg::DATA_W - IW){1'b0}}, r_out_id};
    assign o_m_axis_tuser  = r_out_st;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> design/lwq_checker.sv
// ----------------------------------------------------------------------------
// lwq_checker
// Port-level checks of the linked wait queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lwq_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_m_axis_tvalid,
    input wire logic                       i_m_axis_tready,
    input wire logic [lwq_pkg::DATA_W-1:0] o_m_axis_tdata,
    input wire logic [lwq_pkg::USER_W-1:0] o_m_axis_tuser,
    input wire logic                       o_m_axis_tlast
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // Empty and rejected results carry no identifier and close the item
    a_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == lwq_pkg::ST_EMPTY ||
                            o_m_axis_tuser == lwq_pkg::ST_REJECT) |->
            o_m_axis_tdata == '0 && o_m_axis_tlast)
        else $error("empty or rejected result malformed");

    // A result in the middle of a broadcast always names a waiter
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |->
            o_m_axis_tuser == lwq_pkg::ST_OK && o_m_axis_tdata != '0)
        else $error("broadcast result without a waiter");

    // No status code beyond the defined ones
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tuser == lwq_pkg::ST_OK || o_m_axis_tuser == lwq_pkg::ST_EMPTY ||
            o_m_axis_tuser == lwq_pkg::ST_REJECT)
        else $error("undefined status");

endmodule

bind linked_wait_queue_top lwq_checker u_lwq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

>>> test/linked_wait_queue_top_tb.sv
// ----------------------------------------------------------------------------
// linked_wait_queue_top_tb
// Self-checking bench for the linked wait queue. Requests go in on the slave
// stream in bursts with random gaps, and the master side stalls on shifting
// patterns with one long hold-off. A behavioral copy of the queue predicts
// every item on the result stream: directed rows first, then random traffic
// that mixes waits, signals and broadcasts and fills the whole id space.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module linked_wait_queue_top_tb;

    localparam int IW          = lwq_pkg::ID_W;
    localparam int DW          = lwq_pkg::DATA_W;
    localparam int UW          = lwq_pkg::USER_W;
    localparam int RAND_ITEMS  = 420;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_CYCLES  = 900000;

    typedef struct {
        logic [IW-1:0] woken;
        logic [1:0]    status;
        logic          last;
    } t_wake;

    typedef struct {
        logic [1:0]    mode;
        logic [IW-1:0] tid;
        bit            known;
        logic [IW-1:0] woken;
        logic [1:0]    status;
    } t_req_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_s_axis_tvalid;
    logic            o_s_axis_tready;
    logic [DW-1:0]   i_s_axis_tdata;   // [5:0] thread_id
    logic [UW-1:0]   i_s_axis_tuser;   // [1:0] mode
    logic            o_m_axis_tvalid;
    logic            i_m_axis_tready;
    logic [DW-1:0]   o_m_axis_tdata;   // [5:0] woken_id
    logic [UW-1:0]   o_m_axis_tuser;   // [1:0] status
    logic            o_m_axis_tlast;

    linked_wait_queue_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Predicted queue state and pending results
    logic [IW-1:0] link_tbl [lwq_pkg::TABLE_DEPTH];
    logic [IW-1:0] pred_tail;
    t_wake         wake_q [$];

    int  err_cnt      = 0;
    int  results_seen = 0;
    int  cycle_cnt    = 0;
    int  burst_left   = 0;
    int  req_cnt      = 0;
    bit  hold_done    = 0;

    t_req_row dir_rows [24];

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit is_queued(input logic [IW-1:0] tid);
        return (tid != 0) && ((link_tbl[tid] != 0) || (tid == pred_tail));
    endfunction

    function automatic logic [IW-1:0] pop_head();
        logic [IW-1:0] head;
        head = link_tbl[0];
        if (head != 0) begin
            if (link_tbl[head] == 0)
                pred_tail = '0;
            link_tbl[0] = link_tbl[head];
            link_tbl[head] = '0;
        end
        return head;
    endfunction

    function automatic void push_wake(input logic [IW-1:0] woken, input logic [1:0] st,
                                      input logic lst);
        t_wake w;
        w.woken = woken;
        w.status = st;
        w.last = lst;
        wake_q.push_back(w);
    endfunction

    // Apply one accepted request to the predicted queue, queue its results
    function automatic void queue_step(input logic [1:0] md, input logic [IW-1:0] tid);
        logic [IW-1:0] head;
        int n;
        n = 0;
        case (md)
            lwq_pkg::MODE_WAIT: begin
                if (tid == 0 || int'(tid) >= lwq_pkg::ID_COUNT || is_queued(tid)) begin
                    push_wake('0, lwq_pkg::ST_REJECT, 1'b1);
                end else begin
                    link_tbl[pred_tail] = tid;
                    pred_tail = tid;
                    push_wake('0, lwq_pkg::ST_OK, 1'b1);
                end
            end
            lwq_pkg::MODE_SIGNAL: begin
                head = pop_head();
                push_wake(head, (head == 0) ? lwq_pkg::ST_EMPTY : lwq_pkg::ST_OK, 1'b1);
            end
            lwq_pkg::MODE_BCAST: begin
                if (link_tbl[0] == 0) begin
                    push_wake('0, lwq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    while (n < lwq_pkg::ID_COUNT - 1 && link_tbl[0] != 0) begin
                        head = pop_head();
                        n++;
                        push_wake(head, lwq_pkg::ST_OK,
                                  (n == lwq_pkg::ID_COUNT - 1) || (link_tbl[0] == 0));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one item, inserting a random gap between bursts
    task automatic send_req(input logic [1:0] md, input logic [IW-1:0] tid);
        if (burst_left == 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tdata = DW'($urandom);
            i_s_axis_tuser = UW'($urandom);
            repeat ($urandom_range(0, 7)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = DW'(tid);
        i_s_axis_tuser = md;
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
        if (md != lwq_pkg::MODE_RSVD)
            req_cnt++;
        queue_step(md, tid);
    endtask

    task automatic fill_and_flush();
        int ids [lwq_pkg::ID_COUNT-1];
        int j;
        int t;
        for (int i = 0; i < lwq_pkg::ID_COUNT - 1; i++)
            ids[i] = i + 1;
        for (int i = lwq_pkg::ID_COUNT - 2; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = ids[i];
            ids[i] = ids[j];
            ids[j] = t;
        end
        foreach (ids[i])
            send_req(lwq_pkg::MODE_WAIT, IW'(ids[i]));
        send_req(lwq_pkg::MODE_BCAST, IW'($urandom));
    endtask

    // Stimulus
    initial begin
        t_wake         w;
        logic [1:0]    md;
        logic [IW-1:0] tid;
        int            r;

        dir_rows = '{
            '{lwq_pkg::MODE_SIGNAL, 6'd0,  1'b1, 6'd0,  lwq_pkg::ST_EMPTY},
            '{lwq_pkg::MODE_BCAST,  6'd0,  1'b1, 6'd0,  lwq_pkg::ST_EMPTY},
            '{lwq_pkg::MODE_WAIT,   6'd0,  1'b1, 6'd0,  lwq_pkg::ST_REJECT},
            '{lwq_pkg::MODE_WAIT,   6'd63, 1'b1, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_WAIT,   6'd63, 1'b1, 6'd0,  lwq_pkg::ST_REJECT}, // the tail
            '{lwq_pkg::MODE_WAIT,   6'd1,  1'b1, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_WAIT,   6'd63, 1'b1, 6'd0,  lwq_pkg::ST_REJECT}, // linked
            '{lwq_pkg::MODE_WAIT,   6'd42, 1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_RSVD,   6'd21, 1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_SIGNAL, 6'd0,  1'b1, 6'd63, lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_BCAST,  6'd63, 1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_SIGNAL, 6'd63, 1'b1, 6'd0,  lwq_pkg::ST_EMPTY},
            '{lwq_pkg::MODE_WAIT,   6'd21, 1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_SIGNAL, 6'd0,  1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_WAIT,   6'd21, 1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_WAIT,   6'd42, 1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_WAIT,   6'd21, 1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_SIGNAL, 6'd0,  1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_SIGNAL, 6'd0,  1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_SIGNAL, 6'd0,  1'b1, 6'd0,  lwq_pkg::ST_EMPTY},
            '{lwq_pkg::MODE_RSVD,   6'd63, 1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_WAIT,   6'd5,  1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_BCAST,  6'd0,  1'b0, 6'd0,  lwq_pkg::ST_OK},
            '{lwq_pkg::MODE_BCAST,  6'd42, 1'b1, 6'd0,  lwq_pkg::ST_EMPTY}
        };

        for (int i = 0; i < lwq_pkg::TABLE_DEPTH; i++)
            link_tbl[i] = '0;
        pred_tail = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].mode, dir_rows[i].tid);
            if (dir_rows[i].known) begin
                w = wake_q.pop_back();
                w.woken = dir_rows[i].woken;
                w.status = dir_rows[i].status;
                wake_q.push_back(w);
            end
        end

        // Fill every id once up front so a full-length broadcast is seen
        fill_and_flush();

        while (req_cnt < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                fill_and_flush();
            end else begin
                r = $urandom_range(0, 99);
                tid = IW'($urandom);
                if (r < 50) begin
                    md = lwq_pkg::MODE_WAIT;
                    // mostly fresh ids, some repeats and zero
                    if ($urandom_range(0, 4) != 0) begin
                        for (int k = 0; k < 8 && (tid == 0 || is_queued(tid)); k++)
                            tid = IW'($urandom_range(1, lwq_pkg::ID_COUNT - 1));
                    end
                end else if (r < 80) begin
                    md = lwq_pkg::MODE_SIGNAL;
                end else if (r < 92) begin
                    md = lwq_pkg::MODE_BCAST;
                end else begin
                    md = lwq_pkg::MODE_RSVD;
                end
                send_req(md, tid);
            end
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (wake_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (err_cnt == 0)
            $display("linked_wait_queue_top_tb: clean");
        else
            $display("linked_wait_queue_top_tb: errors");
        $finish;
    end

    // Receiver: shifting stall styles, plus one long hold-off
    initial begin
        int       style;
        int       phase_left;
        bit [7:0] rx_mask;
        style = 0;
        phase_left = 0;
        rx_mask = 8'hff;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= 150) begin
                i_m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            if (phase_left == 0) begin
                style = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 80);
                rx_mask = 8'($urandom) | 8'h01;
            end
            phase_left--;
            case (style)
                0:       i_m_axis_tready = 1'b1;
                1:       i_m_axis_tready = ($urandom_range(0, 9) < 6);
                default: i_m_axis_tready = rx_mask[phase_left % 8];
            endcase
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_wake w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (wake_q.size() == 0) begin
                err_cnt++;
                $display("%0t: expected no result, got id %0d status %0d last %0b", $time,
                         o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
            end else begin
                w = wake_q.pop_front();
                if (o_m_axis_tdata != DW'(w.woken) || o_m_axis_tuser != w.status ||
                    o_m_axis_tlast != w.last) begin
                    err_cnt++;
                    $display("%0t: expected id %0d status %0d last %0b,", $time,
                             w.woken, w.status, w.last);
                    $display("%0t: got id %0d status %0d last %0b", $time,
                             o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("%0t: timeout", $time);
            $display("linked_wait_queue_top_tb: errors");
            $finish;
        end
    end

endmodule
